### rtl/nps_pkg.sv
// Shared types, constants and helper functions for the nearest polyline segment block
`timescale 1ns / 1ps
`default_nettype none
package nps_pkg;
    localparam int COORD_BITS     = 32;
    localparam int INDEX_BITS_DEF = 12;
    localparam int ID_BITS_DEF    = 40;
    localparam int LAT_W   = COORD_BITS - 1;
    localparam int LON_W   = COORD_BITS;
    localparam int SCALE_W = 17;
    localparam int DIST_W  = 31;
    localparam int OFF_W   = 32;
    localparam int SQ_W    = 64;
    localparam int ROOT_W  = 32;
    localparam logic signed [LAT_W-1:0] LAT_MAX = 31'sd900000000;
    localparam logic signed [LON_W-1:0] LON_MAX = 32'sd1800000000;
    localparam logic [DIST_W-1:0] DIST_LIMIT = 31'd1800000000;
    localparam logic [SCALE_W-1:0] SCALE_ONE = 17'd65536;
    localparam logic [1:0] REG_QLAT  = 2'd0;
    localparam logic [1:0] REG_QLON  = 2'd1;
    localparam logic [1:0] REG_SCALE = 2'd2;

    typedef struct packed {
        logic start;
        logic is_sqrt;
    } div_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic signed [LAT_W-1:0] clamp_lat(input logic signed [LAT_W-1:0] v);
        if (v > LAT_MAX) return LAT_MAX;
        if (v < -LAT_MAX) return -LAT_MAX;
        return v;
    endfunction

    function automatic logic signed [LON_W-1:0] clamp_lon(input logic signed [LON_W-1:0] v);
        if (v > LON_MAX) return LON_MAX;
        if (v < -LON_MAX) return -LON_MAX;
        return v;
    endfunction
endpackage
`default_nettype wire

### rtl/nps_if.sv
// Valid/ready channel interface carrying a packed payload
`timescale 1ns / 1ps
`default_nettype none
interface nps_if #(parameter int W = 1) (input wire logic clk);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/nearest_polyline_segment.sv
// Top level: sequencer, shared multiplier and root/divide unit for nearest segment search
//   channel   dir  payload
//   vin       in   vertex_lat, vertex_lon, way_id, vertex_index, first_of_way, last_vertex
//   res       out  best_way, best_index, best_offset, best_distance, found
//   apb       in   query_lat @0x0, query_lon @0x4, cos scale @0x8
// A vertex that forms no segment does not use the root/divide unit. A segment takes one root
// when the nearest point is its start, two roots when it is its end and a root and two divisions
// in between, all worked by the one-bit-a-cycle root/divide unit.
// vin.ready is low while a vertex is worked on; a last vertex also holds while the previous
// result still waits in the output register. rst_n clears control and the per-query state.
`timescale 1ns / 1ps
`default_nettype none
module nearest_polyline_segment
    import nps_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF,
    parameter int ID_BITS    = ID_BITS_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    nps_if.sink        vin,
    nps_if.source      res,
    input  wire logic  psel,
    input  wire logic  penable,
    input  wire logic  pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int IN_W = LAT_W + LON_W + ID_BITS + INDEX_BITS + 2;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIFF  = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_SUM   = 4'd3;
    localparam logic [3:0] S_DEC   = 4'd4;
    localparam logic [3:0] S_ROOT1 = 4'd5;
    localparam logic [3:0] S_DIV1  = 4'd6;
    localparam logic [3:0] S_DIV2  = 4'd7;
    localparam logic [3:0] S_PT    = 4'd8;
    localparam logic [3:0] S_PTR   = 4'd9;
    localparam logic [3:0] S_KEEP  = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;
    localparam logic [3:0] S_WAIT  = 4'd12;

    logic signed [LAT_W-1:0] qlat_cfg;
    logic signed [LON_W-1:0] qlon_cfg;
    logic [SCALE_W-1:0] scale_cfg;

    nps_regs u_regs (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .qlat(qlat_cfg), .qlon(qlon_cfg), .scale(scale_cfg)
    );

    logic [3:0] st_reg, st_next;
    logic [2:0] step_reg, step_next;
    logic signed [LAT_W-1:0] lat_reg, prev_lat_reg;
    logic signed [LON_W-1:0] lon_reg, prev_lon_reg;
    logic [ID_BITS-1:0] way_reg, keep_way_reg;
    logic [INDEX_BITS-1:0] vi_reg, keep_index_reg;
    logic first_reg, last_reg, have_prev_reg, seen_any_reg;
    logic [DIST_W-1:0] min_dist_reg;
    logic [OFF_W-1:0] keep_offset_reg;
    // signed differences: dys, dyp, dye and scaled dxs, dxp, dxe (33 bits covers range)
    logic signed [33:0] dys_reg, dxs_reg, dyp_reg, dxp_reg, dye_reg, dxe_reg;
    logic signed [SQ_W+1:0] acc_reg, dot_reg, crs_reg;
    logic [SQ_W-1:0] l2_reg, len_reg;
    logic [SQ_W-1:0] dist_reg, off_reg;
    logic out_valid_reg;
    logic [ID_BITS+INDEX_BITS+OFF_W+DIST_W:0] out_reg;

    // shared multiplier, 34x34 signed, registered
    logic signed [33:0] ma, mb;
    logic signed [67:0] prod_reg;
    always_ff @(posedge clk) prod_reg <= ma * mb;

    logic signed [LAT_W-1:0] vlat_c, qlat_c;
    logic signed [LON_W-1:0] vlon_c, qlon_c;
    assign vlat_c = clamp_lat(vin.data[IN_W-1 -: LAT_W]);
    assign vlon_c = clamp_lon(vin.data[IN_W-1-LAT_W -: LON_W]);
    assign qlat_c = clamp_lat(qlat_cfg);
    assign qlon_c = clamp_lon(qlon_cfg);

    logic [SCALE_W-1:0] sc;
    assign sc = (scale_cfg > SCALE_ONE) ? SCALE_ONE : scale_cfg;

    // scaled longitude from raw difference: round half away from zero
    logic signed [33:0] lon_raw;
    logic [33:0] lon_mag;
    logic [50:0] lon_prod_reg;
    logic lon_neg_reg;
    logic signed [33:0] lon_scaled;
    always_comb
    begin
        lon_mag = lon_raw[33] ? 34'(-lon_raw) : 34'(lon_raw);
    end
    always_ff @(posedge clk)
    begin
        lon_prod_reg <= lon_mag * sc;
        lon_neg_reg <= lon_raw[33];
    end
    logic [33:0] lon_r;
    assign lon_r = 34'((lon_prod_reg + 51'd32768) >> 16);
    assign lon_scaled = lon_neg_reg ? -$signed(lon_r) : $signed(lon_r);

    div_cmd_t dcmd;
    div_stat_t dstat;
    logic [SQ_W-1:0] dnum, dquo;
    logic [ROOT_W-1:0] dden;
    nps_root_div u_rd (.clk(clk), .rst_n(rst_n), .cmd(dcmd), .num(dnum), .den(dden),
                       .stat(dstat), .quo(dquo));

    logic [SQ_W+1:0] abs_dot, abs_crs;
    assign abs_dot = dot_reg[SQ_W+1] ? '0 : dot_reg[SQ_W+1:0];
    assign abs_crs = crs_reg[SQ_W+1] ? $unsigned(-crs_reg) : $unsigned(crs_reg);

    logic accept;
    assign accept = vin.valid && vin.ready;
    assign vin.ready = (st_reg == S_IDLE);

    logic out_load;
    assign out_load = (st_reg == S_OUT) && (!out_valid_reg || res.ready);

    logic [1:0] mode_reg, mode_next;  // 0 start point, 1 end point, 2 interior
    logic signed [SQ_W+1:0] acc_next, dot_next, crs_next;
    logic [SQ_W-1:0] l2_next, len_next, dist_next, off_next;
    logic signed [33:0] dys_next, dxs_next, dyp_next, dxp_next, dye_next, dxe_next;

    always_comb
    begin
        st_next = st_reg; step_next = step_reg; mode_next = mode_reg;
        ma = '0; mb = '0; lon_raw = '0;
        dcmd = '0; dnum = '0; dden = '0;
        acc_next = acc_reg; dot_next = dot_reg; crs_next = crs_reg; l2_next = l2_reg;
        len_next = len_reg; dist_next = dist_reg; off_next = off_reg;
        dys_next = dys_reg; dxs_next = dxs_reg; dyp_next = dyp_reg; dxp_next = dxp_reg;
        dye_next = dye_reg; dxe_next = dxe_reg;
        case (st_reg)
            S_IDLE:
                if (accept)
                    st_next = S_DIFF;
            S_DIFF:
            begin
                if (first_reg || !have_prev_reg)
                    st_next = last_reg ? S_OUT : S_WAIT;
                else
                begin
                    // three scaled longitudes through the scale multiplier
                    case (step_reg)
                        3'd0: lon_raw = 34'(lon_reg) - 34'(prev_lon_reg);
                        3'd1: begin lon_raw = 34'(qlon_c) - 34'(prev_lon_reg);
                                    dxs_next = lon_scaled; end
                        3'd2: begin lon_raw = 34'(qlon_c) - 34'(lon_reg);
                                    dxp_next = lon_scaled; end
                        default: dxe_next = lon_scaled;
                    endcase
                    dys_next = 34'(lat_reg) - 34'(prev_lat_reg);
                    dyp_next = 34'(qlat_c) - 34'(prev_lat_reg);
                    dye_next = 34'(qlat_c) - 34'(lat_reg);
                    step_next = step_reg + 3'd1;
                    if (step_reg == 3'd3)
                    begin
                        step_next = '0; st_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                // products issued back to back, each accumulated in the next cycle from the registered product
                case (step_reg)
                    3'd0: begin ma = dys_reg; mb = dys_reg; end
                    3'd1: begin ma = dxs_reg; mb = dxs_reg; end
                    3'd2: begin ma = dys_reg; mb = dyp_reg; end
                    3'd3: begin ma = dxs_reg; mb = dxp_reg; end
                    3'd4: begin ma = dys_reg; mb = dxp_reg; end
                    default: begin ma = dxs_reg; mb = dyp_reg; end
                endcase
                case (step_reg)
                    3'd1: acc_next = 66'(prod_reg);
                    3'd2: l2_next = SQ_W'(acc_reg + 66'(prod_reg));
                    3'd3: acc_next = 66'(prod_reg);
                    3'd4: dot_next = acc_reg + 66'(prod_reg);
                    3'd5: acc_next = 66'(prod_reg);
                    default: ;
                endcase
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd5)
                begin
                    step_next = '0; st_next = S_SUM;
                end
            end
            S_SUM:
            begin
                crs_next = acc_reg - 66'(prod_reg);
                st_next = S_DEC;
            end
            S_DEC:
            begin
                if (l2_reg == '0 || dot_reg <= 0)
                begin
                    mode_next = 2'd0; off_next = '0; st_next = S_PT;
                end
                else
                begin
                    mode_next = (abs_dot[SQ_W-1:0] >= l2_reg) ? 2'd1 : 2'd2;
                    dcmd.start = 1'b1; dcmd.is_sqrt = 1'b1; dnum = l2_reg;
                    st_next = S_ROOT1;
                end
            end
            S_ROOT1:
                if (dstat.done)
                begin
                    len_next = dquo;
                    if (mode_reg == 2'd1)
                    begin
                        off_next = dquo; st_next = S_PT;
                    end
                    else
                    begin
                        dcmd.start = 1'b1; dnum = abs_crs[SQ_W-1:0];
                        dden = dquo[ROOT_W-1:0];
                        st_next = S_DIV1;
                    end
                end
            S_DIV1:
                if (dstat.done)
                begin
                    dist_next = dquo;
                    dcmd.start = 1'b1; dnum = abs_dot[SQ_W-1:0];
                    dden = len_reg[ROOT_W-1:0];
                    st_next = S_DIV2;
                end
            S_DIV2:
                if (dstat.done)
                begin
                    off_next = dquo; st_next = S_KEEP;
                end
            S_PT:
            begin
                // point distance: squares then root
                case (step_reg)
                    3'd0: begin ma = (mode_reg == 2'd0) ? dyp_reg : dye_reg; mb = ma; end
                    3'd1: begin ma = (mode_reg == 2'd0) ? dxp_reg : dxe_reg; mb = ma; end
                    default: ;
                endcase
                case (step_reg)
                    3'd1: acc_next = 66'(prod_reg);
                    3'd2:
                    begin
                        dcmd.start = 1'b1; dcmd.is_sqrt = 1'b1;
                        dnum = SQ_W'(acc_reg + 66'(prod_reg));
                    end
                    default: ;
                endcase
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd2)
                begin
                    step_next = '0; st_next = S_PTR;
                end
            end
            S_PTR:
                if (dstat.done)
                begin
                    dist_next = dquo; st_next = S_KEEP;
                end
            S_KEEP:
                st_next = last_reg ? S_OUT : S_WAIT;
            S_OUT:
                if (out_load)
                    st_next = S_IDLE;
            S_WAIT:
                st_next = S_IDLE;
            default:
                st_next = S_IDLE;
        endcase
    end

    logic better;
    assign better = (st_reg == S_KEEP) && (dist_reg <= {33'd0, min_dist_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE; step_reg <= '0; mode_reg <= '0;
            prev_lat_reg <= '0; prev_lon_reg <= '0; have_prev_reg <= 1'b0;
            min_dist_reg <= DIST_LIMIT; keep_way_reg <= '0; keep_index_reg <= '0;
            keep_offset_reg <= '0; seen_any_reg <= 1'b0; out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next; step_reg <= step_next; mode_reg <= mode_next;
            if (better)
            begin
                min_dist_reg <= dist_reg[DIST_W-1:0];
                keep_way_reg <= way_reg;
                keep_index_reg <= vi_reg - INDEX_BITS'(1);
                keep_offset_reg <= off_reg[OFF_W-1:0];
                seen_any_reg <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                have_prev_reg <= 1'b0; seen_any_reg <= 1'b0; min_dist_reg <= DIST_LIMIT;
                keep_way_reg <= '0; keep_index_reg <= '0; keep_offset_reg <= '0;
            end
            else if (res.valid && res.ready)
                out_valid_reg <= 1'b0;
            if (st_reg == S_WAIT)
                have_prev_reg <= 1'b1;
            if (st_next == S_IDLE && st_reg != S_IDLE)
            begin
                prev_lat_reg <= lat_reg; prev_lon_reg <= lon_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lat_reg <= vlat_c; lon_reg <= vlon_c;
            way_reg <= vin.data[IN_W-1-LAT_W-LON_W -: ID_BITS];
            vi_reg <= vin.data[INDEX_BITS+1:2];
            first_reg <= vin.data[1]; last_reg <= vin.data[0];
        end
        acc_reg <= acc_next; dot_reg <= dot_next; crs_reg <= crs_next; l2_reg <= l2_next;
        len_reg <= len_next; dist_reg <= dist_next; off_reg <= off_next;
        dys_reg <= dys_next; dxs_reg <= dxs_next; dyp_reg <= dyp_next; dxp_reg <= dxp_next;
        dye_reg <= dye_next; dxe_reg <= dxe_next;
        if (out_load)
            out_reg <= seen_any_reg ?
                {keep_way_reg, keep_index_reg, keep_offset_reg, min_dist_reg, 1'b1} : '0;
    end

    assign res.valid = out_valid_reg;
    assign res.data = out_reg;

`ifndef NO_ASSERTIONS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != S_IDLE) |-> !vin.ready) else $error("accepted while busy");
    a_out_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_OUT) |-> last_reg) else $error("result without last vertex");
    a_min_bound: assert property (@(posedge clk) disable iff (!rst_n)
        min_dist_reg <= DIST_LIMIT) else $error("min distance out of range");
`endif
endmodule
`default_nettype wire

### rtl/nps_root_div.sv
// Radix-2 digit recurrence unit: integer square root or 64 by 32 division, one bit a cycle
`timescale 1ns / 1ps
`default_nettype none
module nps_root_div
    import nps_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire div_cmd_t          cmd,
    input  wire logic [SQ_W-1:0]   num,
    input  wire logic [ROOT_W-1:0] den,
    output div_stat_t              stat,
    output logic [SQ_W-1:0]        quo
);
    logic [SQ_W-1:0] rem_reg, rem_next, q_reg, q_next, v_reg, v_next;
    logic [ROOT_W-1:0] d_reg, d_next;
    logic [6:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next, done_reg, done_next, sq_reg, sq_next;
    logic [SQ_W:0] rem_sh, trial;
    logic [SQ_W-1:0] bitv;

    always_comb
    begin
        rem_next = rem_reg; q_next = q_reg; v_next = v_reg; d_next = d_reg;
        cnt_next = cnt_reg; busy_next = busy_reg; done_next = 1'b0; sq_next = sq_reg;
        rem_sh = '0; trial = '0; bitv = '0;
        if (cmd.start)
        begin
            busy_next = 1'b1; sq_next = cmd.is_sqrt; v_next = num; d_next = den;
            rem_next = '0; q_next = '0;
            cnt_next = cmd.is_sqrt ? 7'd32 : 7'd64;
        end
        else if (busy_reg)
        begin
            if (sq_reg)
            begin
                // bit-pair step of the classic restoring root
                bitv = 64'd1 << (2 * (cnt_reg - 7'd1));
                trial = {1'b0, q_reg} + {1'b0, bitv};
                if ({1'b0, v_reg} >= trial)
                begin
                    v_next = v_reg - trial[SQ_W-1:0];
                    q_next = (q_reg >> 1) + bitv;
                end
                else
                    q_next = q_reg >> 1;
            end
            else
            begin
                rem_sh = {rem_reg, v_reg[SQ_W-1]};
                v_next = v_reg << 1;
                if (rem_sh >= {33'd0, d_reg})
                begin
                    rem_next = rem_sh[SQ_W-1:0] - {32'd0, d_reg};
                    q_next = {q_reg[SQ_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[SQ_W-1:0];
                    q_next = {q_reg[SQ_W-2:0], 1'b0};
                end
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0; done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0; done_reg <= 1'b0; cnt_reg <= '0; sq_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next; done_reg <= done_next; cnt_reg <= cnt_next;
            sq_reg <= sq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next; q_reg <= q_next; v_reg <= v_next; d_reg <= d_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo = q_reg;
endmodule
`default_nettype wire

### rtl/nps_regs.sv
// APB register file holding the query point and longitude scale
`timescale 1ns / 1ps
`default_nettype none
module nps_regs
    import nps_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output logic signed [LAT_W-1:0] qlat,
    output logic signed [LON_W-1:0] qlon,
    output logic [SCALE_W-1:0]      scale
);
    logic [LAT_W-1:0] qlat_reg;
    logic [LON_W-1:0] qlon_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic wr;
    assign wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qlat_reg <= '0; qlon_reg <= '0; scale_reg <= SCALE_ONE;
        end
        else if (wr && paddr[1:0] == 2'b00)
        begin
            case (paddr[3:2])
                REG_QLAT:  qlat_reg <= pwdata[LAT_W-1:0];
                REG_QLON:  qlon_reg <= pwdata;
                REG_SCALE: scale_reg <= pwdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_QLAT:  prdata = {{(32-LAT_W){qlat_reg[LAT_W-1]}}, qlat_reg};
            REG_QLON:  prdata = qlon_reg;
            REG_SCALE: prdata = {{(32-SCALE_W){1'b0}}, scale_reg};
            default:   prdata = '0;
        endcase
    end

    assign qlat = qlat_reg;
    assign qlon = qlon_reg;
    assign scale = scale_reg;
endmodule
`default_nettype wire
